// ===== sv/lrupr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared widths, codes and structures of the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  // Geometry
  localparam int WAYS       = 8;
  localparam int PAGE_BITS  = 16;
  localparam int FRAME_BITS = 10;
  localparam int IDX_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W      = $clog2(WAYS + 1);
  localparam int WSS_W      = 4;
  localparam int CMP_W      = (CNT_W > WSS_W) ? CNT_W : WSS_W;
  localparam int SLOT_W     = 3;
  localparam int OP_W       = 2;
  localparam int FAULT_W    = 32;

  // Register port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [WSS_W-1:0] WSS_RESET = WSS_W'(8);
  localparam logic REG_WSS = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_PRELOAD = 2'd1,
    OP_ACCESS  = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_TOUCH,
    CMD_RELEASE
  } cmd_kind_t;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [PAGE_BITS-1:0]  page;
    logic [SLOT_W-1:0]     slot;
    logic [FRAME_BITS-1:0] frame_in;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] frame_out;
    logic                  evicted;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [FAULT_W-1:0]    fault_total;
    logic                  no_frame;
  } rsp_t;

  // Scan summary handed from cell to cell
  typedef struct packed {
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      hit_age;
    logic [FRAME_BITS-1:0] hit_frame;
    logic                  free;
    logic [IDX_W-1:0]      free_idx;
    logic [FRAME_BITS-1:0] free_frame;
    logic                  lru;
    logic [IDX_W-1:0]      lru_idx;
    logic [IDX_W-1:0]      lru_age;
    logic [PAGE_BITS-1:0]  lru_page;
    logic [FRAME_BITS-1:0] lru_frame;
    logic [CNT_W-1:0]      res_cnt;
    logic [CNT_W-1:0]      load_cnt;
    logic                  head_valid;
    logic                  head_loaded;
    logic [IDX_W-1:0]      head_age;
    logic [PAGE_BITS-1:0]  head_page;
    logic [FRAME_BITS-1:0] head_frame;
  } carry_t;

  localparam carry_t CARRY_EMPTY = '0;

  // Update broadcast to every cell
  typedef struct packed {
    logic                  en;
    cmd_kind_t             kind;
    logic [IDX_W-1:0]      target;
    logic [IDX_W-1:0]      limit;
    logic                  limit_all;
    logic                  set_valid;
    logic                  write_page;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
  } cmd_t;

endpackage

// ===== sv/lrupr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_req_if / lrupr_rsp_if
// Valid/ready channels carrying requests into and results out of the block.
// ----------------------------------------------------------------------------
interface lrupr_req_if;
  logic              valid;
  logic              ready;
  lrupr_pkg::req_t   data;

  modport src (output valid, output data, input ready);
  modport snk (input valid, input data, output ready);
endinterface

interface lrupr_rsp_if;
  logic              valid;
  logic              ready;
  lrupr_pkg::rsp_t   data;

  modport src (output valid, output data, input ready);
  modport snk (input valid, input data, output ready);
endinterface

// ===== sv/lru_page_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement
// Per-process page residency with LRU replacement over a row of frame slots.
// ----------------------------------------------------------------------------
// Usage:
//   req  : valid/ready request channel (op, page, slot, frame_in).
//   rsp  : valid/ready result channel, one result per request
//          (hit, frame_out, evicted, evicted_page, fault_total, no_frame).
//   APB  : register 0 at byte 0 is working_set_size (4 bits, reset 8);
//          write it only while no request is in flight.
// Timing:
//   A request is taken in the idle cycle, then its scan summary ripples
//   through the registered row of WAYS slot cells, one cell per cycle, and
//   the update is applied in a commit cycle. The result register is loaded
//   at commit. A new request is taken only in the idle state, once the
//   previous one has committed.
// Reset:
//   All slots empty and unloaded, ages and fault count zero, working set 8.
// Stall:
//   The result register holds while rsp.ready is low. A new request is still
//   taken and scanned; its commit waits until the result register frees.
// ----------------------------------------------------------------------------
module lru_page_replacement (
  input  logic                              clk,
  input  logic                              rst,
  lrupr_req_if.snk                          req,
  lrupr_rsp_if.src                          rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lrupr_pkg::PADDR_W-1:0]     paddr,
  input  logic [lrupr_pkg::PDATA_W-1:0]     pwdata,
  output logic [lrupr_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  logic [lrupr_pkg::WSS_W-1:0]     wss;
  logic [lrupr_pkg::PAGE_BITS-1:0] scan_page;
  lrupr_pkg::cmd_t                 cmd;
  lrupr_pkg::carry_t               chain [lrupr_pkg::WAYS];
  logic                            sel_wss;

  // Register port
  assign pready  = 1'b1;
  assign sel_wss = (paddr[lrupr_pkg::PADDR_W-1] == lrupr_pkg::REG_WSS);
  assign prdata  = sel_wss ? lrupr_pkg::PDATA_W'(wss) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wss <= lrupr_pkg::WSS_RESET;
    end else if (psel && penable && pwrite && pready && sel_wss) begin
      wss <= pwdata[lrupr_pkg::WSS_W-1:0];
    end
  end

  // Sequencer
  lrupr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .wss       (wss),
    .tail      (chain[lrupr_pkg::WAYS-1]),
    .scan_page (scan_page),
    .cmd       (cmd)
  );

  // Row of slot cells
  for (genvar i = 0; i < lrupr_pkg::WAYS; i++) begin : g_cell
    lrupr_pkg::carry_t cin;
    if (i == 0) begin : g_head
      assign cin = lrupr_pkg::CARRY_EMPTY;
    end else begin : g_link
      assign cin = chain[i-1];
    end
    lrupr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (lrupr_pkg::IDX_W'(i)),
      .scan_page (scan_page),
      .carry_in  (cin),
      .carry_out (chain[i]),
      .cmd       (cmd)
    );
  end

endmodule

// ===== sv/lrupr_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_cell
// One frame slot: holds page, frame, age and flags, folds itself into the
// registered scan summary passed to its neighbor, and applies updates.
// ----------------------------------------------------------------------------
module lrupr_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [lrupr_pkg::IDX_W-1:0]       idx,
  input  logic [lrupr_pkg::PAGE_BITS-1:0]   scan_page,
  input  lrupr_pkg::carry_t                 carry_in,
  output lrupr_pkg::carry_t                 carry_out,
  input  lrupr_pkg::cmd_t                   cmd
);

  logic [lrupr_pkg::PAGE_BITS-1:0]  page;
  logic [lrupr_pkg::FRAME_BITS-1:0] frame;
  logic [lrupr_pkg::IDX_W-1:0]      age;
  logic                             valid;
  logic                             loaded;
  logic                             match;
  logic                             is_target;
  lrupr_pkg::carry_t                carry_next;

  assign match     = valid && (page == scan_page);
  assign is_target = (cmd.target == idx);

  // Fold this slot into the running summary
  always_comb begin
    carry_next = carry_in;
    if (idx == '0) begin
      carry_next.head_valid  = valid;
      carry_next.head_loaded = loaded;
      carry_next.head_age    = age;
      carry_next.head_page   = page;
      carry_next.head_frame  = frame;
    end
    if (!carry_in.hit && match) begin
      carry_next.hit       = 1'b1;
      carry_next.hit_idx   = idx;
      carry_next.hit_age   = age;
      carry_next.hit_frame = frame;
    end
    if (!carry_in.free && loaded && !valid) begin
      carry_next.free       = 1'b1;
      carry_next.free_idx   = idx;
      carry_next.free_frame = frame;
    end
    if (valid && (!carry_in.lru || (age > carry_in.lru_age))) begin
      carry_next.lru       = 1'b1;
      carry_next.lru_idx   = idx;
      carry_next.lru_age   = age;
      carry_next.lru_page  = page;
      carry_next.lru_frame = frame;
    end
    carry_next.res_cnt  = carry_in.res_cnt + lrupr_pkg::CNT_W'(valid);
    carry_next.load_cnt = carry_in.load_cnt + lrupr_pkg::CNT_W'(loaded);
  end

  // Hand the summary to the next cell
  always_ff @(posedge clk) begin
    carry_out <= carry_next;
  end

  // Apply the broadcast update to page, age and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      page   <= '0;
      age    <= '0;
      valid  <= 1'b0;
      loaded <= 1'b0;
    end else if (cmd.en) begin
      case (cmd.kind)
        lrupr_pkg::CMD_LOAD: begin
          if (is_target) begin
            loaded <= 1'b1;
          end
        end
        lrupr_pkg::CMD_TOUCH: begin
          if (is_target) begin
            age <= '0;
            if (cmd.set_valid) begin
              valid <= 1'b1;
            end
            if (cmd.write_page) begin
              page <= cmd.page;
            end
          end else if (valid && (cmd.limit_all || (age < cmd.limit))) begin
            age <= age + 1'b1;
          end
        end
        lrupr_pkg::CMD_RELEASE: begin
          page   <= '0;
          age    <= '0;
          valid  <= 1'b0;
          loaded <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Frame number, written only by a load
  always_ff @(posedge clk) begin
    if (cmd.en && (cmd.kind == lrupr_pkg::CMD_LOAD) && is_target) begin
      frame <= cmd.frame;
    end
  end

endmodule

// ===== sv/lrupr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Sequencer: takes a request, waits for the scan to ripple down the cell
// row, decides the update and the result, and holds the result register.
// ----------------------------------------------------------------------------
module lrupr_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  lrupr_req_if.snk                          req,
  lrupr_rsp_if.src                          rsp,
  input  logic [lrupr_pkg::WSS_W-1:0]       wss,
  input  lrupr_pkg::carry_t                 tail,
  output logic [lrupr_pkg::PAGE_BITS-1:0]   scan_page,
  output lrupr_pkg::cmd_t                   cmd
);

  lrupr_pkg::state_t                 state;
  lrupr_pkg::state_t                 state_next;
  lrupr_pkg::req_t                   item;
  logic [lrupr_pkg::IDX_W-1:0]       scan_cnt;
  logic [lrupr_pkg::FAULT_W-1:0]     fault;
  logic [lrupr_pkg::FAULT_W-1:0]     fault_next;
  logic                              out_free;
  logic                              commit;
  logic                              scan_done;
  lrupr_pkg::rsp_t                   result;
  lrupr_pkg::cmd_t                   cmd_d;
  logic [lrupr_pkg::CMP_W-1:0]       wss_x;
  logic [lrupr_pkg::CMP_W-1:0]       load_x;
  logic [lrupr_pkg::CMP_W-1:0]       res_x;
  logic [lrupr_pkg::CMP_W-1:0]       cap;

  assign out_free  = !rsp.valid || rsp.ready;
  assign scan_done = (scan_cnt == lrupr_pkg::IDX_W'(lrupr_pkg::WAYS - 1));
  assign commit    = (state == lrupr_pkg::ST_COMMIT) && out_free;
  assign scan_page = item.page;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lrupr_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = lrupr_pkg::ST_SCAN;
        end
      end
      lrupr_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = lrupr_pkg::ST_COMMIT;
        end
      end
      lrupr_pkg::ST_COMMIT: begin
        if (out_free) begin
          state_next = lrupr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lrupr_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs; refuse requests while reset is held
  always_comb begin
    req.ready = (state == lrupr_pkg::ST_IDLE) && !rst;
    cmd       = cmd_d;
    cmd.en    = commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrupr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request and count the scan ripple
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item <= req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (state == lrupr_pkg::ST_SCAN) begin
      scan_cnt <= scan_cnt + 1'b1;
    end else begin
      scan_cnt <= '0;
    end
  end

  // Capacity: smaller of working set size and loaded slot count
  always_comb begin
    wss_x  = lrupr_pkg::CMP_W'(wss);
    load_x = lrupr_pkg::CMP_W'(tail.load_cnt);
    res_x  = lrupr_pkg::CMP_W'(tail.res_cnt);
    cap    = (wss_x < load_x) ? wss_x : load_x;
  end

  // Decide the update and the result from the scan summary
  always_comb begin
    cmd_d        = '0;
    cmd_d.kind   = lrupr_pkg::CMD_NONE;
    cmd_d.page   = item.page;
    cmd_d.frame  = item.frame_in;
    result       = '0;
    fault_next   = fault;
    case (lrupr_pkg::op_t'(item.op))
      lrupr_pkg::OP_LOAD: begin
        if (int'(item.slot) < lrupr_pkg::WAYS) begin
          cmd_d.kind   = lrupr_pkg::CMD_LOAD;
          cmd_d.target = lrupr_pkg::IDX_W'(item.slot);
        end
        result.frame_out = item.frame_in;
      end
      lrupr_pkg::OP_PRELOAD: begin
        if (tail.hit) begin
          cmd_d.kind       = lrupr_pkg::CMD_TOUCH;
          cmd_d.target     = tail.hit_idx;
          cmd_d.limit      = tail.hit_age;
          result.hit       = 1'b1;
          result.frame_out = tail.hit_frame;
        end else if (!tail.head_loaded) begin
          result.no_frame = 1'b1;
        end else begin
          cmd_d.kind       = lrupr_pkg::CMD_TOUCH;
          cmd_d.target     = '0;
          cmd_d.write_page = 1'b1;
          if (tail.head_valid) begin
            cmd_d.limit         = tail.head_age;
            result.evicted      = 1'b1;
            result.evicted_page = tail.head_page;
          end else begin
            cmd_d.set_valid = 1'b1;
            cmd_d.limit_all = 1'b1;
          end
          result.frame_out = tail.head_frame;
        end
      end
      lrupr_pkg::OP_ACCESS: begin
        if (tail.hit) begin
          cmd_d.kind       = lrupr_pkg::CMD_TOUCH;
          cmd_d.target     = tail.hit_idx;
          cmd_d.limit      = tail.hit_age;
          result.hit       = 1'b1;
          result.frame_out = tail.hit_frame;
        end else begin
          if (fault != '1) begin
            fault_next = fault + 1'b1;
          end
          if (cap == '0) begin
            result.no_frame = 1'b1;
          end else if (res_x < cap) begin
            if (tail.free) begin
              cmd_d.kind       = lrupr_pkg::CMD_TOUCH;
              cmd_d.target     = tail.free_idx;
              cmd_d.limit_all  = 1'b1;
              cmd_d.set_valid  = 1'b1;
              cmd_d.write_page = 1'b1;
              result.frame_out = tail.free_frame;
            end else begin
              result.no_frame = 1'b1;
            end
          end else if (tail.lru) begin
            cmd_d.kind          = lrupr_pkg::CMD_TOUCH;
            cmd_d.target        = tail.lru_idx;
            cmd_d.limit         = tail.lru_age;
            cmd_d.write_page    = 1'b1;
            result.evicted      = 1'b1;
            result.evicted_page = tail.lru_page;
            result.frame_out    = tail.lru_frame;
          end else begin
            result.no_frame = 1'b1;
          end
        end
      end
      lrupr_pkg::OP_RELEASE: begin
        cmd_d.kind = lrupr_pkg::CMD_RELEASE;
      end
      default: begin
      end
    endcase
    result.fault_total = fault_next;
  end

  // Fault counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fault <= '0;
    end else if (commit) begin
      fault <= fault_next;
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.data <= result;
    end
  end

endmodule

// ===== sv/lrupr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_checker
// Port-level checks on the result channel of the page replacement block.
// ----------------------------------------------------------------------------
module lrupr_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             rsp_valid,
  input  logic             rsp_ready,
  input  lrupr_pkg::rsp_t  rsp_data
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed");

  // A hit neither evicts nor lacks a frame
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.hit |-> !rsp_data.evicted && !rsp_data.no_frame)
    else $error("hit with eviction or missing frame");

  // No eviction means no evicted page
  a_evict_page: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.evicted |-> rsp_data.evicted_page == '0)
    else $error("evicted page without eviction");

  // Fault total never goes down
  a_fault_mono: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && $past(rsp_valid) |->
      rsp_data.fault_total >= $past(rsp_data.fault_total))
    else $error("fault total decreased");

endmodule

bind lru_page_replacement lrupr_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
